// ===== rtl/fmacl_pkg.sv =====
// ----------------------------------------------------------------------------
// fmacl_pkg
// Types, codes and prefix mask helpers for the first-match address/port ACL.
// ----------------------------------------------------------------------------
package fmacl_pkg;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 8;
  localparam int ADDR_W     = 128;
  localparam int PORT_W     = 16;
  localparam int PREFIX_W   = 8;
  localparam int CFG_W      = 5;
  localparam int LIM_W      = 9;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [1:0] KIND_ANY = 2'd0;
  localparam logic [1:0] KIND_V4  = 2'd1;
  localparam logic [1:0] KIND_V6  = 2'd2;

  localparam logic [1:0] TGT_V4 = 2'd0;
  localparam logic [1:0] TGT_V6 = 2'd1;

  localparam logic [PREFIX_W-1:0] PREFIX_V4_FULL = 8'd32;
  localparam logic [PREFIX_W-1:0] PREFIX_V6_FULL = 8'd128;

  // Input transaction layout, lowest field in the lowest bits.
  typedef struct packed {
    logic [6:0]          pad;
    logic [63:0]         addr_lo;
    logic [63:0]         addr_hi;
    logic [1:0]          target_kind;
    logic [PORT_W-1:0]   port;
    logic [PREFIX_W-1:0] prefix_len;
    logic [1:0]          entry_kind;
    logic                entry_allow;
    logic [3:0]          entry_index;
  } in_item_t;

  typedef struct packed {
    logic                verdict;
    logic [1:0]          family;
    logic [PREFIX_W-1:0] prefix;
    logic [PORT_W-1:0]   port;
    logic [ADDR_W-1:0]   addr;
  } entry_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
  } target_t;

  function automatic logic [31:0] mask32(input logic [PREFIX_W-1:0] p);
    logic [31:0] m;
    for (int i = 0; i < 32; i++) begin
      m[i] = (i >= 32 - int'(p));
    end
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] mask128(input logic [PREFIX_W-1:0] p);
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = (i >= ADDR_W - int'(p));
    end
    return m;
  endfunction

endpackage

// ===== rtl/fmacl_match.sv =====
// ----------------------------------------------------------------------------
// fmacl_match
// Shared compare unit: tests one table entry against the lookup target.
// ----------------------------------------------------------------------------
module fmacl_match (
  input  fmacl_pkg::entry_t  entry_i,
  input  fmacl_pkg::target_t target_i,
  output logic               match_o
);
  import fmacl_pkg::*;

  logic port_ok;
  logic addr_ok;

  assign port_ok = (entry_i.port == '0) || (entry_i.port == target_i.port);

  always_comb begin
    case (entry_i.family)
      KIND_V4: begin
        addr_ok = (target_i.kind == TGT_V4) &&
                  (entry_i.addr[31:0] == (target_i.addr[31:0] & mask32(entry_i.prefix)));
      end
      KIND_V6: begin
        addr_ok = (target_i.kind == TGT_V6) &&
                  (entry_i.addr == (target_i.addr & mask128(entry_i.prefix)));
      end
      default: begin
        addr_ok = 1'b1;
      end
    endcase
  end

  assign match_o = port_ok && addr_ok;

endmodule

// ===== rtl/first_match_address_port_acl_top.sv =====
// ----------------------------------------------------------------------------
// first_match_address_port_acl_top
// Write transaction: ST_DONE registers the result, then ST_IDLE accepts the next.
// Lookup transaction: one entry compared per cycle in ST_SCAN, then ST_DONE and
// ST_IDLE as for a write; entries compared: at most min(active_entries, depth),
// 0 for other target families.
// An unaccepted result holds the sequencer. Reset clears control and
// active_entries; table is undefined until written.
// ----------------------------------------------------------------------------
module first_match_address_port_acl_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmacl_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_index, entry_allow, entry_kind, prefix_len, port, target_kind,
  // addr_hi, addr_lo, zero pad
  input  logic [fmacl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // allow, hit, zero pad
  output logic [fmacl_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import fmacl_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CFG_W-1:0]    active_q;
  target_t             tgt_q, tgt_d;
  logic                res_allow_q, res_allow_d;
  logic                res_hit_q, res_hit_d;
  logic                out_valid_q, out_valid_d;
  logic                out_allow_q, out_allow_d;
  logic                out_hit_q, out_hit_d;

  entry_t              mem_q [TABLE_DEPTH];
  entry_t              rd_q;
  entry_t              wr_entry;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;

  in_item_t            item;
  logic                accept;
  logic                match;
  logic [LIM_W-1:0]    lim_w;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    idx_nxt;
  logic                last;

  assign item          = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign lim_w   = ({{(LIM_W-CFG_W){1'b0}}, active_q} > LIM_W'(TABLE_DEPTH)) ?
                   LIM_W'(TABLE_DEPTH) : {{(LIM_W-CFG_W){1'b0}}, active_q};
  assign limit   = CNT_W'(lim_w);
  assign idx_nxt = idx_q + CNT_W'(1);
  assign last    = (idx_nxt == limit);

  // Mask the entry address to its prefix on write.
  always_comb begin
    wr_entry         = '0;
    wr_entry.verdict = item.entry_allow;
    wr_entry.family  = item.entry_kind;
    wr_entry.port    = item.port;
    case (item.entry_kind)
      KIND_V4: begin
        wr_entry.prefix = (item.prefix_len == '0 || item.prefix_len > PREFIX_V4_FULL) ?
                          PREFIX_V4_FULL : item.prefix_len;
        wr_entry.addr   = {96'd0, item.addr_lo[31:0] & mask32(wr_entry.prefix)};
      end
      KIND_V6: begin
        wr_entry.prefix = (item.prefix_len == '0 || item.prefix_len > PREFIX_V6_FULL) ?
                          PREFIX_V6_FULL : item.prefix_len;
        wr_entry.addr   = {item.addr_hi, item.addr_lo} & mask128(wr_entry.prefix);
      end
      default: begin
        wr_entry.prefix = '0;
        wr_entry.addr   = '0;
      end
    endcase
  end

  assign wr_en  = accept && (s_axis_tuser == MODE_WRITE) &&
                  (LIM_W'(item.entry_index) < LIM_W'(TABLE_DEPTH));
  assign wr_idx = IDX_W'(item.entry_index);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_entry;
    end
    rd_q <= mem_q[idx_d[IDX_W-1:0]];
  end

  fmacl_match u_match (
    .entry_i  (rd_q),
    .target_i (tgt_q),
    .match_o  (match)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    res_allow_d = res_allow_q;
    res_hit_d   = res_hit_q;
    out_valid_d = out_valid_q;
    out_allow_d = out_allow_q;
    out_hit_d   = out_hit_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d       = '0;
          tgt_d.kind  = item.target_kind;
          tgt_d.port  = item.port;
          tgt_d.addr  = {item.addr_hi, item.addr_lo};
          res_allow_d = 1'b0;
          res_hit_d   = 1'b0;
          if (s_axis_tuser == MODE_WRITE || item.target_kind > TGT_V6 || limit == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_allow_d = rd_q.verdict;
          res_hit_d   = 1'b1;
          state_d     = ST_DONE;
        end else if (last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_nxt;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_allow_d = res_allow_q;
          out_hit_d   = res_hit_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    res_allow_q <= res_allow_d;
    res_hit_q   <= res_hit_d;
    out_allow_q <= out_allow_d;
    out_hit_q   <= out_hit_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_hit_q, out_allow_q};

endmodule

// ===== rtl/fmacl_checker.sv =====
// ----------------------------------------------------------------------------
// fmacl_checker
// Port-level checks for the first-match address/port ACL, bound to the top.
// ----------------------------------------------------------------------------
module fmacl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fmacl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import fmacl_pkg::*;

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped before acceptance");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == MODE_WRITE |=> ##1 m_axis_tvalid || $past(m_axis_tvalid))
    else $error("write transaction result missing");

  a_deny_no_allow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("allow without a matching entry");

endmodule

bind first_match_address_port_acl_top fmacl_checker u_fmacl_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for first_match_address_port_acl_top. It runs a directed
// table of writes and lookups, which fills the ACL table, followed by random
// phases. Each phase sets a new scan count while the block is idle.
// Random lookups mostly aim at stored prefixes, some with a bit flipped, and
// the rest are noise. A local model predicts each verdict the directed table
// does not give. Both stream sides idle at random outside quiet phases.
// ----------------------------------------------------------------------------
module testbench;
  import fmacl_pkg::*;

  localparam int TABLE_ROWS = 16;

  typedef struct packed {
    logic hit;
    logic allow;
  } verdict_t;

  typedef struct {
    int       cfg;
    logic     mode;
    in_item_t item;
    logic     typed;
    verdict_t want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [ADDR_W-1:0]   acl_addr[TABLE_ROWS];
  logic [PORT_W-1:0]   acl_port[TABLE_ROWS];
  logic [PREFIX_W-1:0] acl_prefix[TABLE_ROWS];
  logic [1:0]          acl_kind[TABLE_ROWS];
  logic                acl_allow[TABLE_ROWS];
  int                  scan_count;

  verdict_t  verdict_q[$];
  stim_row_t directed_q[$];
  int        errors;
  logic      tx_quiet;
  logic      rx_quiet;

  first_match_address_port_acl_top #(
    .TABLE_DEPTH(TABLE_ROWS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] v4_net_mask(input int p);
    return (p == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - p));
  endfunction

  function automatic logic [ADDR_W-1:0] v6_net_mask(input int p);
    return (p == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - p));
  endfunction

  // Store an entry on a write; scan the table in order on a lookup.
  function automatic verdict_t acl_apply(input logic mode, input in_item_t it);
    verdict_t          v;
    int                p;
    int                n;
    int                plen;
    logic              hit_now;
    logic [ADDR_W-1:0] full;
    v = '0;
    full = {it.addr_hi, it.addr_lo};
    plen = int'(it.prefix_len);
    if (mode == MODE_WRITE) begin
      case (it.entry_kind)
        KIND_V4: begin
          p = (plen == 0 || plen > 32) ? 32 : plen;
          acl_addr[it.entry_index] = {96'd0, it.addr_lo[31:0] & v4_net_mask(p)};
        end
        KIND_V6: begin
          p = (plen == 0 || plen > 128) ? 128 : plen;
          acl_addr[it.entry_index] = full & v6_net_mask(p);
        end
        default: begin
          p = 0;
          acl_addr[it.entry_index] = '0;
        end
      endcase
      acl_prefix[it.entry_index] = p[PREFIX_W-1:0];
      acl_port[it.entry_index]   = it.port;
      acl_kind[it.entry_index]   = it.entry_kind;
      acl_allow[it.entry_index]  = it.entry_allow;
    end else if (it.target_kind == TGT_V4 || it.target_kind == TGT_V6) begin
      n = (scan_count > TABLE_ROWS) ? TABLE_ROWS : scan_count;
      for (int i = 0; i < n; i++) begin
        if (!v.hit) begin
          p = int'(acl_prefix[i]);
          hit_now = (acl_port[i] == '0) || (acl_port[i] == it.port);
          if (acl_kind[i] == KIND_V4) begin
            hit_now = hit_now && (it.target_kind == TGT_V4) &&
                      (acl_addr[i][31:0] == (it.addr_lo[31:0] & v4_net_mask(p)));
          end else if (acl_kind[i] == KIND_V6) begin
            hit_now = hit_now && (it.target_kind == TGT_V6) &&
                      (acl_addr[i] == (full & v6_net_mask(p)));
          end
          if (hit_now) begin
            v.hit   = 1'b1;
            v.allow = acl_allow[i];
          end
        end
      end
    end
    return v;
  endfunction

  task automatic add_row(input int cfg, input logic mode, input int idx, input int allow,
                         input logic [1:0] kind, input int plen, input int port,
                         input logic [1:0] tkind, input longint hi,
                         input longint lo, input int typed, input int ea,
                         input int eh);
    stim_row_t r;
    r.cfg              = cfg;
    r.mode             = mode;
    r.item             = '0;
    r.item.entry_index = idx[3:0];
    r.item.entry_allow = allow[0];
    r.item.entry_kind  = kind;
    r.item.prefix_len  = plen[PREFIX_W-1:0];
    r.item.port        = port[PORT_W-1:0];
    r.item.target_kind = tkind;
    r.item.addr_hi     = hi;
    r.item.addr_lo     = lo;
    r.typed            = typed[0];
    r.want             = '{hit: eh[0], allow: ea[0]};
    directed_q.push_back(r);
  endtask

  task automatic send_item(input logic mode, input in_item_t it, input logic typed,
                           input verdict_t want);
    int       gap;
    verdict_t v;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = it;
    s_axis_tuser  = mode;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    v = acl_apply(mode, it);
    verdict_q.push_back(typed ? want : v);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_scan_count(input int value);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value[CFG_W-1:0];
    scan_count  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic make_random_item(output logic mode, output in_item_t it);
    int                r;
    int                j;
    int                p;
    int                b;
    logic [ADDR_W-1:0] full;
    logic [ADDR_W-1:0] m;
    r    = $urandom_range(0, 99);
    it   = '0;
    full = {$urandom, $urandom, $urandom, $urandom};
    it.entry_index = 4'($urandom);
    it.entry_allow = 1'($urandom);
    it.entry_kind  = 2'($urandom);
    it.prefix_len  = PREFIX_W'($urandom);
    it.port        = PORT_W'($urandom);
    it.target_kind = 2'($urandom);
    if (r < 25) begin
      mode = MODE_WRITE;
      j = $urandom_range(0, 99);
      it.entry_kind = (j < 45) ? KIND_V4 : (j < 90) ? KIND_V6 : (j < 96) ? KIND_ANY : 2'd3;
      if ($urandom_range(0, 9) < 7) begin
        it.prefix_len = PREFIX_W'((it.entry_kind == KIND_V6) ? $urandom_range(1, 128)
                                                             : $urandom_range(1, 32));
      end
      if ($urandom_range(0, 1) == 0) begin
        it.port = '0;
      end
    end else if (r < 85) begin
      mode = MODE_LOOKUP;
      j = $urandom_range(0, TABLE_ROWS - 1);
      p = int'(acl_prefix[j]);
      case (acl_kind[j])
        KIND_V4: begin
          it.target_kind = TGT_V4;
          full[31:0] = (acl_addr[j][31:0] & v4_net_mask(p)) | (full[31:0] & ~v4_net_mask(p));
        end
        KIND_V6: begin
          it.target_kind = TGT_V6;
          m = v6_net_mask(p);
          full = (acl_addr[j] & m) | (full & ~m);
        end
        default: it.target_kind = 2'($urandom_range(0, 1));
      endcase
      if (acl_port[j] != '0 && $urandom_range(0, 3) != 0) begin
        it.port = acl_port[j];
      end
      if ($urandom_range(0, 4) == 0) begin
        b = $urandom_range(0, ADDR_W - 1);
        full[b] = ~full[b];
      end
    end else begin
      mode = MODE_LOOKUP;
    end
    it.addr_hi = full[127:64];
    it.addr_lo = full[63:0];
  endtask

  // Receiver: drop tready at random before each transaction, except in quiet phases.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $error("unexpected result transaction: tdata %h", m_axis_tdata);
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (m_axis_tdata[0] !== want.allow) begin
          errors++;
          $error("allow mismatch: expected %0b, actual %0b", want.allow, m_axis_tdata[0]);
        end
        if (m_axis_tdata[1] !== want.hit) begin
          errors++;
          $error("hit mismatch: expected %0b, actual %0b", want.hit, m_axis_tdata[1]);
        end
      end
    end
  end

  initial begin
    logic     mode;
    in_item_t it;
    int       cfg;
    errors        = 0;
    scan_count    = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_WRITE;

    add_row(-1, MODE_LOOKUP, 0, 1, KIND_ANY, 0, 80, TGT_V4, 0, 64'h0A01_0203, 1, 0, 0);
    add_row(-1, MODE_WRITE, 0, 1, KIND_V4, 0, 80, TGT_V4, '1, 64'h0A01_0203, 1, 0, 0);
    add_row(-1, MODE_WRITE, 1, 0, KIND_V4, 255, 0, TGT_V4, 0, '1, 1, 0, 0);
    add_row(-1, MODE_WRITE, 2, 1, KIND_V4, 1, 65535, TGT_V4, 0, 64'h8000_0000, 1, 0, 0);
    add_row(-1, MODE_WRITE, 3, 1, KIND_V6, 0, 443, TGT_V6, 64'h2001_0DB8_0000_0001,
            64'h42, 1, 0, 0);
    add_row(-1, MODE_WRITE, 4, 0, KIND_V6, 129, 0, TGT_V6, '1, '1, 1, 0, 0);
    add_row(-1, MODE_WRITE, 5, 1, KIND_V6, 64, 0, TGT_V6, 64'hFE80_0000_0000_0000, '1,
            1, 0, 0);
    add_row(-1, MODE_WRITE, 6, 0, KIND_V6, 65, 8080, TGT_V6, 64'h2001_0DB8_AAAA_0000,
            64'hC000_0000_0000_0001, 1, 0, 0);
    add_row(-1, MODE_WRITE, 7, 0, KIND_V6, 1, 0, TGT_V6, 64'h8000_0000_0000_0000, 0,
            1, 0, 0);
    add_row(-1, MODE_WRITE, 8, 1, KIND_V6, 128, 53, TGT_V6, 0, 1, 1, 0, 0);
    add_row(-1, MODE_WRITE, 9, 1, 2'd3, 77, 22, 2'd3, '1, '1, 1, 0, 0);
    add_row(-1, MODE_WRITE, 10, 1, KIND_V4, 33, 25, TGT_V4, 0, 64'hC0A8_0101, 1, 0, 0);
    add_row(-1, MODE_WRITE, 11, 0, KIND_V4, 32, 0, TGT_V4, 0, 64'h7F00_0001, 1, 0, 0);
    add_row(-1, MODE_WRITE, 12, 1, KIND_V6, 127, 0, TGT_V6, 64'h2001_0DB8_0000_0002, '1,
            1, 0, 0);
    add_row(-1, MODE_WRITE, 13, 1, KIND_V4, 31, 0, TGT_V4, 0, 64'h0A00_0001, 1, 0, 0);
    add_row(-1, MODE_WRITE, 14, 0, KIND_ANY, 255, 0, TGT_V4, '1, '1, 1, 0, 0);
    add_row(-1, MODE_WRITE, 15, 1, KIND_ANY, 0, 65535, TGT_V4, 0, 0, 1, 0, 0);
    add_row(16, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 80, TGT_V4, 0, 64'h0A01_0203, 0, 0, 0);
    add_row(-1, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 80, 2'd2, 0, 64'h0A01_0203, 1, 0, 0);
    add_row(-1, MODE_LOOKUP, 15, 1, 2'd3, 255, 65535, 2'd3, '1, '1, 1, 0, 0);
    add_row(-1, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 443, TGT_V6, 64'h2001_0DB8_0000_0001,
            64'h42, 0, 0, 0);
    add_row(-1, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 65535, TGT_V4, 0, 64'hFFFF_FFFF, 0, 0, 0);
    add_row(-1, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 0, TGT_V6, 0, 0, 0, 0, 0);
    add_row(31, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 1, TGT_V4, 0, 0, 0, 0, 0);
    add_row(0, MODE_LOOKUP, 0, 0, KIND_ANY, 0, 53, TGT_V6, 0, 1, 1, 0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_q[k]) begin
      if (directed_q[k].cfg >= 0) begin
        set_scan_count(directed_q[k].cfg);
      end
      send_item(directed_q[k].mode, directed_q[k].item, directed_q[k].typed,
                directed_q[k].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       cfg = 16;
        1:       cfg = 0;
        2:       cfg = 31;
        3:       cfg = 1;
        default: cfg = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31)
                                                    : $urandom_range(2, 16);
      endcase
      set_scan_count(cfg);
      tx_quiet = (ph % 4 == 3);
      rx_quiet = (ph % 4 == 1) || (ph % 4 == 3);
      repeat (150) begin
        make_random_item(mode, it);
        send_item(mode, it, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fmacl_pkg.sv
rtl/fmacl_match.sv
rtl/first_match_address_port_acl_top.sv
rtl/fmacl_checker.sv
dv/testbench.sv
